@@ hw/rtl/rts_pkg.sv @@
// shared types, timing constants and frame builder for the remote frame transmitter
// no dependencies; imported by every module of the block except rts_fifo
`default_nettype none

package rts_pkg;

	// segment lengths in one-microsecond ticks
	localparam int unsigned TICK_W = 17;
	localparam logic [TICK_W-1:0] HALF_TICKS    = TICK_W'(640);
	localparam logic [TICK_W-1:0] WAKE_HI_TICKS = TICK_W'(9415);
	localparam logic [TICK_W-1:0] WAKE_LO_TICKS = TICK_W'(89565);
	localparam logic [TICK_W-1:0] HW_SYNC_TICKS = TICK_W'(2560);
	localparam logic [TICK_W-1:0] SW_SYNC_TICKS = TICK_W'(4550);
	localparam logic [TICK_W-1:0] GAP_TICKS     = TICK_W'(30415);

	localparam int unsigned FRAME_W = 56;
	localparam logic [7:0]  FRAME_KEY = 8'hA7;
	localparam int unsigned ADDR_W = 24;

	localparam logic [2:0] FIRST_SYNCS    = 3'd2;
	localparam logic [2:0] REPEAT_SYNCS   = 3'd7;
	localparam logic [1:0] FRAME_COUNT    = 2'd3;
	localparam logic [5:0] BITS_PER_FRAME = 6'd56;

	// opcode of an input item
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  button;
		logic [15:0] roll_code;
	} in_item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic accepted;
		logic done_res;
	} out_item_t;

	// classified item passed from front to back
	typedef struct packed {
		logic               is_cmd;
		logic [FRAME_W-1:0] frame;
	} work_item_t;

	// build the obscured 56-bit frame, byte 0 in the top bits
	function automatic logic [FRAME_W-1:0] make_frame(input logic [3:0] button,
			input logic [15:0] code, input logic [ADDR_W-1:0] addr);
		logic [7:0] b [7];
		logic [3:0] sum;
		logic [FRAME_W-1:0] packed_frame;
		b[0] = FRAME_KEY;
		b[1] = {button, 4'h0};
		b[2] = code[15:8];
		b[3] = code[7:0];
		b[4] = addr[23:16];
		b[5] = addr[15:8];
		b[6] = addr[7:0];
		sum = 4'h0;
		for (int i = 0; i < 7; i++) begin
			sum = sum ^ b[i][7:4] ^ b[i][3:0];
		end
		b[1] = b[1] | {4'h0, sum};
		for (int i = 1; i < 7; i++) begin
			b[i] = b[i] ^ b[i-1];
		end
		packed_frame = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
		return packed_frame;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rts_fifo.sv @@
// small register-based queue used between the front, the back and the result side
// no package dependencies
`default_nettype none

module rts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rts_front.sv @@
// front end: holds the remote address, classifies items and builds the frame
// depends on rts_pkg
`default_nettype none

module rts_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire rts_pkg::in_item_t           item,
	output logic                             full,
	input  wire logic                        cfg_we,
	input  wire logic [rts_pkg::ADDR_W-1:0]  cfg_data,
	output logic                             q_push,
	output rts_pkg::work_item_t              q_data,
	input  wire logic                        q_full
);

	import rts_pkg::*;

	logic [ADDR_W-1:0] addr_q;

	// remote address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cfg_we) begin
			addr_q <= cfg_data;
		end
	end

	// classify and hand over to the work queue
	assign full          = q_full;
	assign q_push        = push && !q_full;
	assign q_data.is_cmd = (item.opcode == OP_CMD);
	assign q_data.frame  = make_frame(item.button, item.roll_code, addr_q);

endmodule

`default_nettype wire

@@ hw/rtl/rts_sequencer.sv @@
// back end: waveform sequencer that plays wake, syncs, data bits and gaps
// depends on rts_pkg
`default_nettype none

module rts_sequencer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire rts_pkg::work_item_t work,
	output rts_pkg::out_item_t       res
);

	import rts_pkg::*;

	typedef enum logic [3:0] {
		SEG_WAKE_HI = 4'd0,
		SEG_WAKE_LO = 4'd1,
		SEG_HW_HI   = 4'd2,
		SEG_HW_LO   = 4'd3,
		SEG_SW_HI   = 4'd4,
		SEG_SW_LO   = 4'd5,
		SEG_DATA    = 4'd6,
		SEG_GAP     = 4'd7,
		SEG_IDLE    = 4'd15
	} seg_t;

	seg_t               seg_q,   seg_d;
	logic [FRAME_W-1:0] frame_q, frame_d;
	logic [1:0]         frame_num_q, frame_num_d;
	logic [2:0]         sync_left_q, sync_left_d;
	logic [5:0]         bit_pos_q, bit_pos_d;
	logic               second_q, second_d;
	logic [TICK_W-1:0]  ticks_q, ticks_d;
	logic               active_q, active_d;
	logic [TICK_W-1:0]  ticks_dec;
	logic [5:0]         bit_pos_inc;
	logic [1:0]         frame_num_inc;
	logic [2:0]         sync_dec;

	assign ticks_dec     = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
	assign bit_pos_inc   = bit_pos_q + 1'b1;
	assign frame_num_inc = frame_num_q + 1'b1;
	assign sync_dec      = sync_left_q - 1'b1;

	// next state and result for the item at the head of the work queue
	always_comb begin
		seg_d       = seg_q;
		frame_d     = frame_q;
		frame_num_d = frame_num_q;
		sync_left_d = sync_left_q;
		bit_pos_d   = bit_pos_q;
		second_d    = second_q;
		ticks_d     = ticks_q;
		active_d    = active_q;
		res         = '0;
		if (work.is_cmd) begin
			// start a transmission unless one is running
			if (!active_q) begin
				frame_d     = work.frame;
				active_d    = 1'b1;
				frame_num_d = '0;
				sync_left_d = FIRST_SYNCS;
				bit_pos_d   = '0;
				second_d    = 1'b0;
				seg_d       = SEG_WAKE_HI;
				ticks_d     = WAKE_HI_TICKS;
				res.accepted = 1'b1;
			end
			res.busy_res = 1'b1;
		end else if (active_q) begin
			res.busy_res = 1'b1;
			// pin level for this tick
			case (seg_q)
				SEG_WAKE_HI, SEG_HW_HI, SEG_SW_HI: res.line_level = 1'b1;
				SEG_DATA: res.line_level = second_q ? frame_q[FRAME_W-1] : !frame_q[FRAME_W-1];
				default: res.line_level = 1'b0;
			endcase
			ticks_d = ticks_dec;
			// segment end
			if (ticks_dec == '0) begin
				unique case (seg_q)
					SEG_WAKE_HI: begin
						seg_d = SEG_WAKE_LO; ticks_d = WAKE_LO_TICKS;
					end
					SEG_WAKE_LO: begin
						seg_d = SEG_HW_HI; ticks_d = HW_SYNC_TICKS;
					end
					SEG_HW_HI: begin
						seg_d = SEG_HW_LO; ticks_d = HW_SYNC_TICKS;
					end
					SEG_HW_LO: begin
						sync_left_d = sync_dec;
						if (sync_dec != '0) begin
							seg_d = SEG_HW_HI; ticks_d = HW_SYNC_TICKS;
						end else begin
							seg_d = SEG_SW_HI; ticks_d = SW_SYNC_TICKS;
						end
					end
					SEG_SW_HI: begin
						seg_d = SEG_SW_LO; ticks_d = HALF_TICKS;
					end
					SEG_SW_LO: begin
						bit_pos_d = '0; second_d = 1'b0;
						seg_d = SEG_DATA; ticks_d = HALF_TICKS;
					end
					SEG_DATA: begin
						if (!second_q) begin
							second_d = 1'b1; ticks_d = HALF_TICKS;
						end else begin
							// rotate so the frame is whole again after the last bit
							second_d  = 1'b0;
							bit_pos_d = bit_pos_inc;
							frame_d   = {frame_q[FRAME_W-2:0], frame_q[FRAME_W-1]};
							if (bit_pos_inc >= BITS_PER_FRAME) begin
								seg_d = SEG_GAP; ticks_d = GAP_TICKS;
							end else begin
								ticks_d = HALF_TICKS;
							end
						end
					end
					default: begin
						if (frame_num_inc >= FRAME_COUNT) begin
							active_d    = 1'b0;
							seg_d       = SEG_IDLE;
							frame_num_d = '0;
							sync_left_d = '0;
							bit_pos_d   = '0;
							second_d    = 1'b0;
							ticks_d     = '0;
							res.done_res = 1'b1;
						end else begin
							frame_num_d = frame_num_inc;
							sync_left_d = REPEAT_SYNCS;
							seg_d       = SEG_HW_HI;
							ticks_d     = HW_SYNC_TICKS;
						end
					end
				endcase
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= SEG_IDLE;
			frame_q     <= '0;
			frame_num_q <= '0;
			sync_left_q <= '0;
			bit_pos_q   <= '0;
			second_q    <= 1'b0;
			ticks_q     <= '0;
			active_q    <= 1'b0;
		end else if (step) begin
			seg_q       <= seg_d;
			frame_q     <= frame_d;
			frame_num_q <= frame_num_d;
			sync_left_q <= sync_left_d;
			bit_pos_q   <= bit_pos_d;
			second_q    <= second_d;
			ticks_q     <= ticks_d;
			active_q    <= active_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rts_remote_frame_transmitter.sv @@
// top level of the remote frame transmitter: front end, work queue, sequencer, result queue
// depends on rts_pkg, rts_front, rts_fifo and rts_sequencer
//
// channel   dir  handshake     payload
// item      in   push / full   rts_pkg::in_item_t: opcode, button, roll_code
// result    out  pop / empty   rts_pkg::out_item_t: line_level, busy_res, accepted, done_res
// config    in   cfg_we        cfg_data: 24-bit remote address
//
// one item per clock cycle sustained while the result side keeps popping; each item gives exactly one result
// a result reaches the ports through two registered stages: the work queue, then the result queue
// the sequencer steps only when the work queue has an item and the result queue has room,
// so a stalled result side backs up into full without losing items
// reset clears the queues, the sequencer (idle) and the remote address

`default_nettype none

module rts_remote_frame_transmitter #(
	parameter int WORK_DEPTH   = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire rts_pkg::in_item_t          item,
	output logic                            full,
	output logic                            empty,
	input  wire logic                       pop,
	output rts_pkg::out_item_t              result,
	input  wire logic                       cfg_we,
	input  wire logic [rts_pkg::ADDR_W-1:0] cfg_data
);

	import rts_pkg::*;

	logic       wq_push;
	work_item_t wq_wdata;
	logic       wq_full;
	work_item_t wq_rdata;
	logic       wq_empty;
	logic       rq_full;
	logic       step;
	out_item_t  seq_res;

	// front end
	rts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_push   (wq_push),
		.q_data   (wq_wdata),
		.q_full   (wq_full)
	);

	// work queue between front and back
	rts_fifo #(
		.WIDTH ($bits(work_item_t)),
		.DEPTH (WORK_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.wdata  (wq_wdata),
		.full   (wq_full),
		.pop    (step),
		.rdata  (wq_rdata),
		.empty  (wq_empty)
	);

	// back end steps when an item waits and there is room for its result
	assign step = !wq_empty && !rq_full;

	rts_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.work   (wq_rdata),
		.res    (seq_res)
	);

	// result queue
	rts_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (RESULT_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.wdata  (seq_res),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

@@ sim/rts_remote_frame_transmitter_test.sv @@
// self-checking bench for rts_remote_frame_transmitter: random and directed command/tick items
// with an in-bench pin waveform predictor; depends on rts_pkg and the transmitter rtl
`timescale 1ns / 1ps

module rts_remote_frame_transmitter_test;

	import rts_pkg::*;

	// waveform timing in one-microsecond ticks
	localparam logic [16:0] T_HALF    = 17'd640;
	localparam logic [16:0] T_WAKE_HI = 17'd9415;
	localparam logic [16:0] T_WAKE_LO = 17'd89565;
	localparam logic [16:0] T_HW_SYNC = 17'd2560;
	localparam logic [16:0] T_SW_SYNC = 17'd4550;
	localparam logic [16:0] T_GAP     = 17'd30415;
	localparam logic [7:0]  KEY_BYTE  = 8'hA7;
	localparam int          FRAME_LEN = 56;
	localparam int          HOLD_CYCLES = 300;

	typedef enum logic [3:0] {
		PH_WAKE_HI = 4'd0,
		PH_WAKE_LO = 4'd1,
		PH_HW_HI   = 4'd2,
		PH_HW_LO   = 4'd3,
		PH_SW_HI   = 4'd4,
		PH_SW_LO   = 4'd5,
		PH_DATA    = 4'd6,
		PH_GAP     = 4'd7,
		PH_IDLE    = 4'd15
	} tx_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	in_item_t    item = '0;
	logic        full;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   result;
	logic        cfg_we = 1'b0;
	logic [23:0] cfg_data = '0;

	// predictor state
	logic [23:0] exp_addr = '0;
	logic [55:0] exp_frame = '0;
	tx_phase_t   seg = PH_IDLE;
	logic [1:0]  frame_no = '0;
	logic [2:0]  syncs_left = '0;
	logic [5:0]  bit_idx = '0;
	logic        late_half = 1'b0;
	logic [16:0] ticks = '0;
	logic        sending = 1'b0;

	in_item_t    item_q[$];
	out_item_t   pin_exp_q[$];
	int          mismatch_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	logic        hold_req = 1'b0;
	int          hold_left = 0;

	rts_remote_frame_transmitter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// key, button, checksum, code and address, then each byte chained with the one before
	function automatic logic [55:0] scramble_frame(input logic [3:0] btn,
			input logic [15:0] code, input logic [23:0] adr);
		logic [55:0] plain;
		logic [55:0] chained;
		logic [3:0]  chk;
		plain = {KEY_BYTE, btn, 4'h0, code, adr};
		chk = 4'h0;
		for (int n = 0; n < 14; n++) begin
			chk = chk ^ plain[n*4 +: 4];
		end
		plain[43:40] = chk;
		chained[55:48] = plain[55:48];
		for (int k = 1; k < 7; k++) begin
			chained[55-8*k -: 8] = plain[55-8*k -: 8] ^ chained[63-8*k -: 8];
		end
		return chained;
	endfunction

	function automatic void enter_phase(input tx_phase_t p);
		seg = p;
		case (p)
			PH_WAKE_HI: ticks = T_WAKE_HI;
			PH_WAKE_LO: ticks = T_WAKE_LO;
			PH_HW_HI, PH_HW_LO: ticks = T_HW_SYNC;
			PH_SW_HI: ticks = T_SW_SYNC;
			PH_GAP: ticks = T_GAP;
			default: ticks = T_HALF;
		endcase
	endfunction

	// segment ran out: move on; returns 1 when the last gap ends
	function automatic logic advance_phase();
		case (seg)
			PH_WAKE_HI: enter_phase(PH_WAKE_LO);
			PH_WAKE_LO: enter_phase(PH_HW_HI);
			PH_HW_HI: enter_phase(PH_HW_LO);
			PH_HW_LO: begin
				syncs_left = syncs_left - 3'd1;
				enter_phase(syncs_left != 3'd0 ? PH_HW_HI : PH_SW_HI);
			end
			PH_SW_HI: enter_phase(PH_SW_LO);
			PH_SW_LO: begin
				bit_idx = '0;
				late_half = 1'b0;
				enter_phase(PH_DATA);
			end
			PH_DATA: begin
				if (!late_half) begin
					late_half = 1'b1;
				end else begin
					late_half = 1'b0;
					bit_idx = bit_idx + 6'd1;
				end
				enter_phase(bit_idx >= FRAME_LEN ? PH_GAP : PH_DATA);
			end
			default: begin
				frame_no = frame_no + 2'd1;
				if (frame_no >= 2'd3) begin
					sending = 1'b0;
					seg = PH_IDLE;
					frame_no = '0;
					syncs_left = '0;
					bit_idx = '0;
					late_half = 1'b0;
					ticks = '0;
					return 1'b1;
				end
				syncs_left = 3'd7;
				enter_phase(PH_HW_HI);
			end
		endcase
		return 1'b0;
	endfunction

	// expected pin sample for one transferred item
	function automatic out_item_t transmit_step(input in_item_t it);
		out_item_t r;
		logic      data_bit;
		r = '0;
		if (it.opcode == OP_CMD) begin
			if (!sending) begin
				exp_frame = scramble_frame(it.button, it.roll_code, exp_addr);
				sending = 1'b1;
				frame_no = '0;
				syncs_left = 3'd2;
				bit_idx = '0;
				late_half = 1'b0;
				enter_phase(PH_WAKE_HI);
				r.accepted = 1'b1;
			end
			r.busy_res = sending;
		end else if (sending) begin
			r.busy_res = 1'b1;
			case (seg)
				PH_WAKE_HI, PH_HW_HI, PH_SW_HI: r.line_level = 1'b1;
				PH_DATA: begin
					data_bit = exp_frame[FRAME_LEN - 1 - bit_idx];
					r.line_level = late_half ? data_bit : ~data_bit;
				end
				default: r.line_level = 1'b0;
			endcase
			if (ticks != '0) begin
				ticks = ticks - 17'd1;
			end
			if (ticks == '0) begin
				r.done_res = advance_phase();
			end
		end
		return r;
	endfunction

	function automatic in_item_t make_item(input logic op, input logic [3:0] btn,
			input logic [15:0] code);
		in_item_t it;
		it.opcode = op;
		it.button = btn;
		it.roll_code = code;
		return it;
	endfunction

	function automatic in_item_t random_item(input int cmd_pct);
		return make_item(($urandom_range(99, 0) < cmd_pct) ? OP_CMD : OP_TICK,
			4'($urandom), 16'($urandom));
	endfunction

	task automatic flag_error(input string msg);
		mismatch_cnt++;
		$display("%0t ERROR: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic got, input logic want_bit);
		if (got !== want_bit) begin
			flag_error($sformatf("%s got %b want %b", name, got, want_bit));
		end
	endtask

	// item side: predict at each transfer, then offer the next pending item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				pin_exp_q.push_back(transmit_step(item));
			end
			if (!push || !full) begin
				if (item_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					push <= 1'b1;
					item <= item_q.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long result-side hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result side pop
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_pin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pin_exp_q.size() == 0) begin
				flag_error("result transfer with nothing predicted");
			end else begin
				want = pin_exp_q.pop_front();
				check_field("line_level", result.line_level, want.line_level);
				check_field("busy_res", result.busy_res, want.busy_res);
				check_field("accepted", result.accepted, want.accepted);
				check_field("done_res", result.done_res, want.done_res);
			end
		end
	end

	task automatic wait_drained();
		while (item_q.size() != 0 || push || pin_exp_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_address(input logic [23:0] adr);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= adr;
		exp_addr = adr;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_random(input int count, input int cmd_pct);
		repeat (count) begin
			item_q.push_back(random_item(cmd_pct));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// slow receiver; directed items first, address still at its reset value
		send_idle_pct = 22;
		recv_idle_pct = 76;
		item_q.push_back(make_item(OP_TICK, 4'hF, 16'hFFFF));
		item_q.push_back(make_item(OP_TICK, 4'h0, 16'h0000));
		item_q.push_back(make_item(OP_CMD, 4'hF, 16'hFFFF));
		item_q.push_back(make_item(OP_CMD, 4'h0, 16'h0000));
		queue_random(6, 0);
		item_q.push_back(make_item(OP_CMD, 4'h5, 16'hA5A5));
		item_q.push_back(make_item(OP_CMD, 4'hA, 16'h5A5A));
		queue_random(6, 0);
		// receiver stops for a while so the block fills and holds off the sender
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		queue_random(230, 12);
		wait_drained();
		write_address(24'($urandom));

		// slow sender
		send_idle_pct = 76;
		recv_idle_pct = 22;
		queue_random(250, 12);
		wait_drained();
		write_address(24'hFFFFFF);

		// full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(250, 12);
		wait_drained();

		repeat (10) @(posedge clk);
		if (pin_exp_q.size() != 0) begin
			flag_error("predicted results never arrived");
		end
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

endmodule
